/* rtl/bezier_path_flattener_unit_assert.svh */
// assertion macros shared by the rtl
`ifndef BEZIER_PATH_FLATTENER_UNIT_ASSERT_SVH
`define BEZIER_PATH_FLATTENER_UNIT_ASSERT_SVH

// same-cycle implication
`define BPF_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bpf_pkg.sv */
`default_nettype none
package bpf_pkg;
    localparam int TYPE_W     = 3;
    localparam int TOL_W      = 23;
    localparam int DEPTH_W    = 3;
    localparam int SEG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int MUL_W      = 64;

    localparam logic [TYPE_W-1:0] REQ_MOVE  = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_LINE  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_QUAD  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_CUBIC = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_CLOSE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGMENTS = 2'd2;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 23'd64;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd5;
    localparam logic [SEG_W-1:0]   SEG_RESET   = 16'hFFFF;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } t_mul_rsp;
endpackage
`default_nettype wire

/* rtl/bpf_if.sv */
`default_nettype none
interface bpf_in_if #(parameter int COORD_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic [bpf_pkg::TYPE_W-1:0]    req_type;
    logic signed [COORD_BITS-1:0]  p_x;
    logic signed [COORD_BITS-1:0]  p_y;
    logic signed [COORD_BITS-1:0]  c1_x;
    logic signed [COORD_BITS-1:0]  c1_y;
    logic signed [COORD_BITS-1:0]  c2_x;
    logic signed [COORD_BITS-1:0]  c2_y;
    logic                          path_start;
    modport source (output valid, req_type, p_x, p_y, c1_x, c1_y, c2_x, c2_y, path_start,
                    input ready);
    modport sink (input valid, req_type, p_x, p_y, c1_x, c1_y, c2_x, c2_y, path_start,
                  output ready);
endinterface

interface bpf_out_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic                         starts_subpath;
    logic                         last;
    logic                         budget_exceeded;
    modport source (output valid, pt_x, pt_y, starts_subpath, last, budget_exceeded,
                    input ready);
    modport sink (input valid, pt_x, pt_y, starts_subpath, last, budget_exceeded,
                  output ready);
endinterface

interface bpf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bpf_pkg::CFG_IDX_W-1:0]    index;
    logic [bpf_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/bpf_mul.sv */
`default_nettype none
module bpf_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpf_pkg::t_mul_req i_req,
    output bpf_pkg::t_mul_rsp o_rsp
);
    logic [bpf_pkg::MUL_W-1:0]   r_a;
    logic [bpf_pkg::MUL_W-1:0]   r_b;
    logic [bpf_pkg::MUL_W-1:0]   r_pp;
    logic [2*bpf_pkg::MUL_W-1:0] r_acc;
    logic                        r_busy;
    logic                        r_done;
    logic [2:0]                  r_cnt;

    logic [31:0]                 w_ap;
    logic [31:0]                 w_bp;
    logic [63:0]                 w_pp;
    logic [2*bpf_pkg::MUL_W-1:0] w_add;

    // partial order: lo*lo, lo*hi, hi*lo, hi*hi
    assign w_ap = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bp = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_ap * w_bp;

    always_comb begin
        unique case (r_cnt)
            3'd1:    w_add = {64'd0, r_pp};
            3'd2:    w_add = {32'd0, r_pp, 32'd0};
            3'd3:    w_add = {32'd0, r_pp, 32'd0};
            3'd4:    w_add = {r_pp, 64'd0};
            default: w_add = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp <= w_pp;
            end
            r_acc <= r_acc + w_add;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
endmodule
`default_nettype wire

/* rtl/bezier_path_flattener_unit.sv */
// Bezier path flattener: one path segment (move, line, quadratic, cubic, close) per input
// transfer, polyline points out, the final point of a segment marked by last. The input
// is not ready while a segment is being worked on. A curve first squares the tolerance,
// then each piece runs a flatness test made of six to eight products of 64-bit operands
// on one shared 32x32 multiplier; a cubic piece repeats the test when the first one
// passes, for its second control point. A cubic at depth 5 may test 31 pieces and emit
// 32 points. The multiplier sets the rate. Pending right halves sit in a MAX_DEPTH-row
// stack; a pop passes through the read state and then the load state. Configuration
// writes are always ready and must be made while idle.
`default_nettype none
`include "bezier_path_flattener_unit_assert.svh"
module bezier_path_flattener_unit #(
    parameter int MAX_DEPTH  = 5,
    parameter int COORD_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpf_in_if.sink    i_in,
    bpf_out_if.source o_out,
    bpf_cfg_if.sink   i_cfg
);
    localparam int C     = COORD_BITS;
    localparam int DW    = bpf_pkg::DEPTH_W;
    localparam int PW    = $clog2(MAX_DEPTH + 1);
    localparam int SW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ROW_W = 8 * C + DW;
    localparam logic [DW-1:0] DEPTH_CAP = DW'(MAX_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OUT   = 8'b0000_0010,
        S_NODE  = 8'b0000_0100,
        S_MGO   = 8'b0000_1000,
        S_MWT   = 8'b0001_0000,
        S_CEMIT = 8'b0010_0000,
        S_RD    = 8'b0100_0000,
        S_LD    = 8'b1000_0000
    } t_state;

    typedef enum logic [3:0] {
        K_TOL, K_LX, K_LY, K_DX, K_DY, K_EX, K_EY, K_CA, K_CB, K_CS, K_CT
    } t_kstep;

    t_state r_state, n_state;
    t_kstep r_k, n_k;

    logic [bpf_pkg::TOL_W-1:0] r_tol, n_tol;
    logic [DW-1:0]             r_maxd, n_maxd;
    logic [bpf_pkg::SEG_W-1:0] r_maxseg, n_maxseg;
    logic signed [C-1:0]       r_cx, n_cx, r_cy, n_cy, r_sx, n_sx, r_sy, n_sy;
    logic                      r_hc, n_hc;
    logic [bpf_pkg::SEG_W-1:0] r_budget, n_budget;
    logic                      r_flag, n_flag;
    logic signed [C-1:0]       r_w [8];
    logic signed [C-1:0]       n_w [8];
    logic [DW-1:0]             r_depth, n_depth;
    logic [PW-1:0]             r_pend, n_pend;
    logic                      r_cubic, n_cubic;
    logic                      r_sel, n_sel;
    logic [63:0]               r_tol2, n_tol2, r_len2, n_len2, r_acc, n_acc;
    logic [63:0]               r_ex, n_ex, r_ey, n_ey, r_cr, n_cr;
    logic [127:0]              r_wide, n_wide;
    logic                      r_o_valid, n_o_valid;
    logic signed [C-1:0]       r_o_x, n_o_x, r_o_y, n_o_y;
    logic                      r_o_start, n_o_start, r_o_last, n_o_last, r_o_flag, n_o_flag;

    logic [ROW_W-1:0]          r_stack [MAX_DEPTH];
    logic [ROW_W-1:0]          r_rd;

    logic                      w_in_fire, w_out_fire, w_push;
    logic [DW-1:0]             w_limit;
    logic signed [C-1:0]       w_px, w_py;
    logic [63:0]               w_dx, w_dy, w_abx, w_aby, w_bdx, w_bdy, w_sum;
    logic signed [C-1:0]       w_l [8];
    logic signed [C-1:0]       w_r [8];
    logic [ROW_W-1:0]          w_row;
    bpf_pkg::t_mul_req         w_mreq;
    bpf_pkg::t_mul_rsp         w_mrsp;

    function automatic logic signed [C-1:0] f_half(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
        logic signed [C:0] s;
        s = {a[C-1], a} + {b[C-1], b};
        return s[C:1];
    endfunction

    function automatic logic [63:0] f_diff(input logic signed [C-1:0] a,
                                          input logic signed [C-1:0] b);
        logic signed [C:0] d;
        d = {a[C-1], a} - {b[C-1], b};
        return 64'(d);
    endfunction

    function automatic logic [63:0] f_abs(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    bpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = r_o_valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_o_valid;
    assign o_out.pt_x            = r_o_x;
    assign o_out.pt_y            = r_o_y;
    assign o_out.starts_subpath  = r_o_start;
    assign o_out.last            = r_o_last;
    assign o_out.budget_exceeded = r_o_flag;

    assign w_limit = (r_maxd < DEPTH_CAP) ? r_maxd : DEPTH_CAP;
    assign w_px    = r_sel ? r_w[4] : r_w[2];
    assign w_py    = r_sel ? r_w[5] : r_w[3];
    assign w_dx    = f_diff(w_px, r_w[0]);
    assign w_dy    = f_diff(w_py, r_w[1]);
    assign w_abx   = f_diff(r_w[6], r_w[0]);
    assign w_aby   = f_diff(r_w[7], r_w[1]);
    assign w_bdx   = f_diff(w_px, r_w[6]);
    assign w_bdy   = f_diff(w_py, r_w[7]);
    assign w_sum   = r_acc + w_mrsp.prod[63:0];

    always_comb begin
        w_mreq.start = (r_state == S_MGO);
        unique case (r_k)
            K_TOL:   begin w_mreq.a = 64'(r_tol); w_mreq.b = 64'(r_tol); end
            K_LX:    begin w_mreq.a = w_abx;      w_mreq.b = w_abx;      end
            K_LY:    begin w_mreq.a = w_aby;      w_mreq.b = w_aby;      end
            K_DX:    begin w_mreq.a = w_dx;       w_mreq.b = w_abx;      end
            K_DY:    begin w_mreq.a = w_dy;       w_mreq.b = w_aby;      end
            K_EX:    begin w_mreq.a = r_ex;       w_mreq.b = r_ex;       end
            K_EY:    begin w_mreq.a = r_ey;       w_mreq.b = r_ey;       end
            K_CA:    begin w_mreq.a = w_dx;       w_mreq.b = w_aby;      end
            K_CB:    begin w_mreq.a = w_dy;       w_mreq.b = w_abx;      end
            K_CS:    begin w_mreq.a = r_cr;       w_mreq.b = r_cr;       end
            K_CT:    begin w_mreq.a = r_tol2;     w_mreq.b = r_len2;     end
            default: begin w_mreq.a = '0;         w_mreq.b = '0;         end
        endcase
    end

    // midpoint split of the current piece, x and y lanes
    always_comb begin
        logic signed [C-1:0] m01, m12, m23, m012, m123, mm;
        for (int j = 0; j < 2; j++) begin
            m01 = f_half(r_w[j], r_w[2+j]);
            if (r_cubic) begin
                m12  = f_half(r_w[2+j], r_w[4+j]);
                m23  = f_half(r_w[4+j], r_w[6+j]);
                m012 = f_half(m01, m12);
                m123 = f_half(m12, m23);
                mm   = f_half(m012, m123);
                w_l[j] = r_w[j]; w_l[2+j] = m01;  w_l[4+j] = m012; w_l[6+j] = mm;
                w_r[j] = mm;     w_r[2+j] = m123; w_r[4+j] = m23;  w_r[6+j] = r_w[6+j];
            end else begin
                m12  = f_half(r_w[2+j], r_w[6+j]);
                m23  = m12;
                m012 = m01;
                m123 = m12;
                mm   = f_half(m01, m12);
                w_l[j] = r_w[j]; w_l[2+j] = m01; w_l[4+j] = m01; w_l[6+j] = mm;
                w_r[j] = mm;     w_r[2+j] = m12; w_r[4+j] = m12; w_r[6+j] = r_w[6+j];
            end
        end
        for (int j = 0; j < 8; j++) begin
            w_row[j*C +: C] = w_r[j];
        end
        w_row[8*C +: DW] = r_depth + DW'(1);
    end

    always_comb begin
        logic v_hc, v_flag, v_got, v_res, v_decide, v_leaf;
        logic signed [C-1:0] v_cx, v_cy, v_sx, v_sy;
        logic [bpf_pkg::SEG_W-1:0] v_budget;

        n_state = r_state;   n_k = r_k;
        n_tol = r_tol;       n_maxd = r_maxd;   n_maxseg = r_maxseg;
        n_cx = r_cx;         n_cy = r_cy;       n_sx = r_sx;   n_sy = r_sy;
        n_hc = r_hc;         n_budget = r_budget;              n_flag = r_flag;
        n_w = r_w;           n_depth = r_depth; n_pend = r_pend;
        n_cubic = r_cubic;   n_sel = r_sel;
        n_tol2 = r_tol2;     n_len2 = r_len2;   n_acc = r_acc;
        n_ex = r_ex;         n_ey = r_ey;       n_cr = r_cr;   n_wide = r_wide;
        n_o_valid = r_o_valid; n_o_x = r_o_x;   n_o_y = r_o_y;
        n_o_start = r_o_start; n_o_last = r_o_last; n_o_flag = r_o_flag;
        w_push   = 1'b0;
        v_got    = 1'b0;
        v_res    = 1'b0;
        v_decide = 1'b0;
        v_leaf   = 1'b0;
        v_hc     = i_in.path_start ? 1'b0 : r_hc;
        v_flag   = i_in.path_start ? 1'b0 : r_flag;
        v_cx     = i_in.path_start ? '0 : r_cx;
        v_cy     = i_in.path_start ? '0 : r_cy;
        v_sx     = i_in.path_start ? '0 : r_sx;
        v_sy     = i_in.path_start ? '0 : r_sy;
        v_budget = i_in.path_start ? r_maxseg : r_budget;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bpf_pkg::CFG_TOLERANCE:    n_tol    = i_cfg.data;
                bpf_pkg::CFG_MAX_DEPTH:    n_maxd   = i_cfg.data[DW-1:0];
                bpf_pkg::CFG_MAX_SEGMENTS: n_maxseg = i_cfg.data[bpf_pkg::SEG_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_hc = v_hc; n_flag = v_flag; n_budget = v_budget;
                    n_cx = v_cx; n_cy = v_cy; n_sx = v_sx; n_sy = v_sy;
                    n_o_x = i_in.p_x; n_o_y = i_in.p_y;
                    n_o_start = 1'b0; n_o_last = 1'b1;
                    unique case (i_in.req_type)
                        bpf_pkg::REQ_MOVE, bpf_pkg::REQ_LINE,
                        bpf_pkg::REQ_QUAD, bpf_pkg::REQ_CUBIC: begin
                            if (!v_hc || i_in.req_type == bpf_pkg::REQ_MOVE) begin
                                n_cx = i_in.p_x; n_cy = i_in.p_y;
                                n_sx = i_in.p_x; n_sy = i_in.p_y;
                                n_hc = 1'b1;
                                n_o_start = 1'b1;
                                n_o_valid = 1'b1;
                                n_state = S_OUT;
                            end else if (i_in.req_type == bpf_pkg::REQ_LINE) begin
                                if (v_budget == '0) begin
                                    n_flag = 1'b1;
                                end else begin
                                    n_budget = v_budget - 1'b1;
                                end
                                n_cx = i_in.p_x; n_cy = i_in.p_y;
                                n_o_valid = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_cubic = (i_in.req_type == bpf_pkg::REQ_CUBIC);
                                n_w[0] = v_cx;      n_w[1] = v_cy;
                                n_w[2] = i_in.c1_x; n_w[3] = i_in.c1_y;
                                n_w[4] = n_cubic ? i_in.c2_x : i_in.c1_x;
                                n_w[5] = n_cubic ? i_in.c2_y : i_in.c1_y;
                                n_w[6] = i_in.p_x;  n_w[7] = i_in.p_y;
                                n_depth = '0;
                                n_pend  = '0;
                                n_k     = K_TOL;
                                n_state = S_MGO;
                            end
                        end
                        bpf_pkg::REQ_CLOSE: begin
                            if (v_hc && (v_cx != v_sx || v_cy != v_sy)) begin
                                n_o_x = v_sx; n_o_y = v_sy;
                                n_o_valid = 1'b1;
                                n_state = S_OUT;
                            end
                            n_hc = 1'b0;
                        end
                        default: ;
                    endcase
                    n_o_flag = n_flag;
                end
            end
            S_OUT: begin
                if (w_out_fire) begin
                    n_o_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_NODE: begin
                if (r_depth >= w_limit) begin
                    v_decide = 1'b1;
                    v_leaf   = 1'b1;
                end else begin
                    n_sel = 1'b0;
                    n_k = K_LX;
                    n_state = S_MGO;
                end
            end
            S_MGO: n_state = S_MWT;
            S_MWT: begin
                if (w_mrsp.done) begin
                    n_state = S_MGO;
                    unique case (r_k)
                        K_TOL: begin n_tol2 = w_mrsp.prod[63:0]; n_state = S_NODE; end
                        K_LX:  begin n_acc = w_mrsp.prod[63:0]; n_k = K_LY; end
                        K_LY:  begin n_len2 = w_sum; n_k = K_DX; end
                        K_DX:  begin n_acc = w_mrsp.prod[63:0]; n_k = K_DY; end
                        K_DY: begin
                            n_k = K_EX;
                            if (r_len2 == '0 || $signed(w_sum) <= 64'sd0) begin
                                n_ex = w_dx; n_ey = w_dy;
                            end else if ($signed(r_len2) <= $signed(w_sum)) begin
                                n_ex = w_bdx; n_ey = w_bdy;
                            end else begin
                                n_k = K_CA;
                            end
                        end
                        K_EX:  begin n_acc = w_mrsp.prod[63:0]; n_k = K_EY; end
                        K_EY:  begin v_got = 1'b1; v_res = (w_sum <= r_tol2); end
                        K_CA:  begin n_acc = w_mrsp.prod[63:0]; n_k = K_CB; end
                        K_CB:  begin n_cr = f_abs(r_acc - w_mrsp.prod[63:0]); n_k = K_CS; end
                        K_CS:  begin n_wide = w_mrsp.prod; n_k = K_CT; end
                        K_CT:  begin v_got = 1'b1; v_res = (r_wide <= w_mrsp.prod); end
                        default: n_state = S_IDLE;
                    endcase
                    if (v_got) begin
                        if (v_res && r_cubic && !r_sel) begin
                            n_sel = 1'b1;
                            n_k = K_LX;
                        end else begin
                            v_decide = 1'b1;
                            v_leaf   = v_res;
                        end
                    end
                end
            end
            S_CEMIT: begin
                if (w_out_fire) begin
                    n_o_valid = 1'b0;
                    if (r_pend == '0) begin
                        n_cx = r_w[6]; n_cy = r_w[7];
                        n_state = S_IDLE;
                    end else begin
                        n_pend = r_pend - PW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_LD;
            S_LD: begin
                for (int j = 0; j < 8; j++) begin
                    n_w[j] = r_rd[j*C +: C];
                end
                n_depth = r_rd[8*C +: DW];
                n_state = S_NODE;
            end
            default: n_state = S_IDLE;
        endcase

        if (v_decide) begin
            if (!v_leaf && r_budget == '0) begin
                n_flag = 1'b1;
                v_leaf = 1'b1;
            end
            if (v_leaf) begin
                n_o_valid = 1'b1;
                n_o_x = r_w[6]; n_o_y = r_w[7];
                n_o_start = 1'b0;
                n_o_last = (r_pend == '0);
                n_o_flag = n_flag;
                n_state = S_CEMIT;
            end else begin
                n_budget = r_budget - 1'b1;
                w_push = 1'b1;
                n_w = w_l;
                n_depth = r_depth + DW'(1);
                n_pend = r_pend + PW'(1);
                n_state = S_NODE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_pend[SW-1:0]] <= w_row;
        end
        r_rd <= r_stack[r_pend[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= K_TOL;
            r_tol     <= bpf_pkg::TOL_RESET;
            r_maxd    <= bpf_pkg::DEPTH_RESET;
            r_maxseg  <= bpf_pkg::SEG_RESET;
            r_cx      <= '0;
            r_cy      <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_hc      <= 1'b0;
            r_budget  <= bpf_pkg::SEG_RESET;
            r_flag    <= 1'b0;
            r_depth   <= '0;
            r_pend    <= '0;
            r_sel     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_tol     <= n_tol;
            r_maxd    <= n_maxd;
            r_maxseg  <= n_maxseg;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_hc      <= n_hc;
            r_budget  <= n_budget;
            r_flag    <= n_flag;
            r_depth   <= n_depth;
            r_pend    <= n_pend;
            r_sel     <= n_sel;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_cubic   <= n_cubic;
        r_tol2    <= n_tol2;
        r_len2    <= n_len2;
        r_acc     <= n_acc;
        r_ex      <= n_ex;
        r_ey      <= n_ey;
        r_cr      <= n_cr;
        r_wide    <= n_wide;
        r_o_x     <= n_o_x;
        r_o_y     <= n_o_y;
        r_o_start <= n_o_start;
        r_o_last  <= n_o_last;
        r_o_flag  <= n_o_flag;
    end

    `BPF_ASSERT_NEXT(a_last_idle, w_out_fire && r_o_last, r_state == S_IDLE, "not idle after last")
    `BPF_ASSERT_IMM(a_pend_bound, r_state != S_IDLE, r_pend <= PW'(MAX_DEPTH), "stack overflow")
    `BPF_ASSERT_IMM(a_mul_wait, w_mrsp.done, r_state == S_MWT, "product arrived unexpectedly")
    `BPF_ASSERT_IMM(a_out_state, r_o_valid, r_state == S_OUT || r_state == S_CEMIT,
                    "output valid outside emit")
endmodule
`default_nettype wire
